// ===== rtl/pzvc_pkg.sv =====
// Shared types and constants of the pan/zoom view camera.
package pzvc_pkg;

   // Sequencer states, one-hot.
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_ZSETUP = 9'b000000010,
      ST_DIV    = 9'b000000100,
      ST_CLAMP  = 9'b000001000,
      ST_MUL_X  = 9'b000010000,
      ST_ACC_X  = 9'b000100000,
      ST_ACC_Y  = 9'b001000000,
      ST_ZOP    = 9'b010000000,
      ST_RESULT = 9'b100000000
   } state_type;

   // Command codes.
   localparam logic [2:0] OP_PAN        = 3'd0;
   localparam logic [2:0] OP_ZOOM       = 3'd1;
   localparam logic [2:0] OP_SET_Z      = 3'd2;
   localparam logic [2:0] OP_STEP_Z     = 3'd3;
   localparam logic [2:0] OP_INVALIDATE = 3'd4;

   // Register indexes.
   localparam logic [1:0] CSR_SCREEN_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_PYRAMID_LEVELS = 2'd2;

   // Register reset values.
   localparam logic [13:0] WIDTH_RESET  = 14'd1024;
   localparam logic [13:0] HEIGHT_RESET = 14'd768;
   localparam logic [4:0]  LEVELS_RESET = 5'd1;

   // Scale limits and view reset values.
   localparam logic [26:0]        SCALE_LO  = 27'd524288;
   localparam logic [26:0]        SCALE_HI  = 27'd67108864;
   localparam logic [26:0]        ONE_Q24   = 27'd16777216;
   localparam logic signed [31:0] HALF_Q24  = 32'sd8388608;

   // Divider: quotient bits produced one per cycle.
   localparam int DIV_STEPS   = 27;
   localparam int DIV_COUNT_W = $clog2(DIV_STEPS);

endpackage

// ===== rtl/pan_zoom_view_camera.sv =====
// Top level of the pan/zoom view camera: command sequencer, shared divider and multiplier.
//
//   Channel   Direction  Handshake            Payload
//   req_*     in         req_valid/req_stall  operation, pan deltas, zoom factor, pivot, z
//   rsp_*     out        rsp_valid/rsp_stall  center, scale, depth, change count, mip level
//   csr_*     in         csr_write_enable     csr_index, csr_write_data
//
// One command is worked on at a time; req_stall is high from the transfer in until the
// sequencer returns to idle. Invalidate goes straight to the result state; set z and step z
// pass through the depth state; a pan runs the multiply and accumulate states; a zoom
// first runs the radix-2 divider, which yields one quotient bit a cycle, unless the factor
// is zero or the quotient would overflow, in which case the divide is skipped.
// The result sits in an output register, so a new command is taken while it waits.
// A stalled result holds the sequencer in its result state until the register frees.
// Reset is synchronous and restores the view and the registers at once.
module pan_zoom_view_camera
   import pzvc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_operation,
   input  logic signed [15:0]  req_delta_x,
   input  logic signed [15:0]  req_delta_y,
   input  logic [23:0]         req_zoom_factor,
   input  logic [16:0]         req_pivot_x,
   input  logic [16:0]         req_pivot_y,
   input  logic signed [31:0]  req_z_value,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_view_center_x,
   output logic signed [31:0]  rsp_view_center_y,
   output logic [26:0]         rsp_view_scale,
   output logic signed [31:0]  rsp_view_depth,
   output logic [31:0]         rsp_change_count,
   output logic [3:0]          rsp_mip_level,

   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [13:0]         csr_write_data
);

   // Saturates a wide signed sum to the signed 32 bit range.
   function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
      logic signed [31:0] r;
      if ((v[43:31] == 13'h0000) || (v[43:31] == 13'h1fff)) begin
         r = v[31:0];
      end else if (v[43]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7fff_ffff;
      end
      return r;
   endfunction

   // Mip level from the leading one of the scale. The scale never drops below 1/32,
   // so the leading one of a scale below one lies in bits 23 down to 19.
   function automatic logic [3:0] mip_of(input logic [26:0] s, input logic [4:0] levels);
      logic [4:0] base;
      logic       pow2;
      logic [4:0] lvl;
      logic [3:0] r;
      if (s[23]) begin
         base = 5'd1;
         pow2 = (s[22:0] == 23'd0);
      end else if (s[22]) begin
         base = 5'd2;
         pow2 = (s[21:0] == 22'd0);
      end else if (s[21]) begin
         base = 5'd3;
         pow2 = (s[20:0] == 21'd0);
      end else if (s[20]) begin
         base = 5'd4;
         pow2 = (s[19:0] == 20'd0);
      end else begin
         base = 5'd5;
         pow2 = (s[18:0] == 19'd0);
      end
      lvl = pow2 ? base : base - 5'd1;
      if ((levels <= 5'd1) || (s >= ONE_Q24)) begin
         r = 4'd0;
      end else if (lvl >= levels) begin
         r = 4'(levels - 5'd1);
      end else begin
         r = lvl[3:0];
      end
      return r;
   endfunction

   // Sequencer.
   state_type state_ff, state_in;

   // Configuration registers.
   logic [13:0] width_ff, width_in;
   logic [13:0] height_ff, height_in;
   logic [4:0]  levels_ff, levels_in;

   // View state.
   logic signed [31:0] center_x_ff, center_x_in;
   logic signed [31:0] center_y_ff, center_y_in;
   logic [26:0]        scale_ff, scale_in;
   logic signed [31:0] depth_ff, depth_in;
   logic [31:0]        count_ff, count_in;

   // Command held for the duration of its work.
   logic [2:0]         op_ff, op_in;
   logic signed [15:0] dx_ff, dx_in;
   logic signed [15:0] dy_ff, dy_in;
   logic [23:0]        factor_ff, factor_in;
   logic [16:0]        px_ff, px_in;
   logic [16:0]        py_ff, py_in;
   logic signed [31:0] zv_ff, zv_in;

   // Divider, clamp and multiplier pipeline registers.
   logic [23:0]            rem_ff, rem_in;
   logic [26:0]            quo_ff, quo_in;
   logic [DIV_COUNT_W-1:0] div_count_ff, div_count_in;
   logic [26:0]            ns_ff, ns_in;
   logic signed [27:0]     diff_ff, diff_in;
   logic signed [45:0]     prod_ff, prod_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_cx_ff, rsp_cx_in;
   logic signed [31:0] rsp_cy_ff, rsp_cy_in;
   logic [26:0]        rsp_scale_ff, rsp_scale_in;
   logic signed [31:0] rsp_depth_ff, rsp_depth_in;
   logic [31:0]        rsp_count_ff, rsp_count_in;
   logic [3:0]         rsp_mip_ff, rsp_mip_in;

   logic               req_accept;
   logic               pan_sel;
   logic               sel_y;
   logic signed [17:0] dx_ext, dy_ext, ox, oy;
   logic signed [17:0] mul_a;
   logic signed [27:0] mul_b;
   logic signed [45:0] mul_p;
   logic signed [45:0] prod_rnd;
   logic signed [41:0] rnd;
   logic signed [31:0] acc_src;
   logic signed [43:0] acc_sum;
   logic signed [31:0] acc_sat;
   logic signed [43:0] z_sum;
   logic [24:0]        div_trial;
   logic [24:0]        div_sub;
   logic               div_ge;
   logic               div_big;
   logic [26:0]        ns_clamped;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Shared multiplier: the pan delta by the scale, or the pivot offset by the scale change.
   // The x product is formed first; the y product is formed while x is accumulated.
   assign pan_sel = (op_ff == OP_PAN);
   assign sel_y   = (state_ff == ST_ACC_X);
   assign dx_ext  = {{2{dx_ff[15]}}, dx_ff};
   assign dy_ext  = {{2{dy_ff[15]}}, dy_ff};
   assign ox      = $signed({1'b0, px_ff}) - $signed({1'b0, width_ff, 3'b000});
   assign oy      = $signed({1'b0, py_ff}) - $signed({1'b0, height_ff, 3'b000});
   assign mul_a   = pan_sel ? (sel_y ? dy_ext : dx_ext) : (sel_y ? oy : ox);
   assign mul_b   = pan_sel ? $signed({1'b0, scale_ff}) : diff_ff;
   assign mul_p   = mul_a * mul_b;

   // Shared accumulator: round the Q.28 product to Q.24, add or subtract, saturate.
   assign prod_rnd = prod_ff + 46'sd8;
   assign rnd      = prod_rnd[45:4];
   assign acc_src  = (state_ff == ST_ACC_Y) ? center_y_ff : center_x_ff;
   assign acc_sum  = pan_sel ? ({{12{acc_src[31]}}, acc_src} - {{2{rnd[41]}}, rnd})
                             : ({{12{acc_src[31]}}, acc_src} + {{2{rnd[41]}}, rnd});
   assign acc_sat  = sat32(acc_sum);

   assign z_sum = {{12{depth_ff[31]}}, depth_ff} + {{12{zv_ff[31]}}, zv_ff};

   // Restoring divider step: the partial remainder stays below the factor.
   assign div_trial = {rem_ff, quo_ff[26]};
   assign div_sub   = div_trial - {1'b0, factor_ff};
   assign div_ge    = (div_trial >= {1'b0, factor_ff});

   // A zero factor, or a quotient that would need more than 27 bits, gives the maximum.
   assign div_big = (factor_ff == 24'd0) || ({8'd0, scale_ff[26:11]} >= factor_ff);

   assign ns_clamped = (quo_ff < SCALE_LO) ? SCALE_LO :
                       (quo_ff > SCALE_HI) ? SCALE_HI : quo_ff;

   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      levels_in    = levels_ff;
      center_x_in  = center_x_ff;
      center_y_in  = center_y_ff;
      scale_in     = scale_ff;
      depth_in     = depth_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      factor_in    = factor_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      zv_in        = zv_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_count_in = div_count_ff;
      ns_in        = ns_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cx_in    = rsp_cx_ff;
      rsp_cy_in    = rsp_cy_ff;
      rsp_scale_in = rsp_scale_ff;
      rsp_depth_in = rsp_depth_ff;
      rsp_count_in = rsp_count_ff;
      rsp_mip_in   = rsp_mip_ff;

      // The user must write registers only while no command is in flight; the block does not enforce it.
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:   width_in  = csr_write_data;
            CSR_SCREEN_HEIGHT:  height_in = csr_write_data;
            CSR_PYRAMID_LEVELS: levels_in = csr_write_data[4:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in     = req_operation;
               dx_in     = req_delta_x;
               dy_in     = req_delta_y;
               factor_in = req_zoom_factor;
               px_in     = req_pivot_x;
               py_in     = req_pivot_y;
               zv_in     = req_z_value;
               if (req_operation inside {[OP_PAN:OP_INVALIDATE]}) begin
                  count_in = count_ff + 32'd1;
               end
               case (req_operation)
                  OP_PAN:    state_in = ST_MUL_X;
                  OP_ZOOM:   state_in = ST_ZSETUP;
                  OP_SET_Z:  state_in = ST_ZOP;
                  OP_STEP_Z: state_in = ST_ZOP;
                  default:   state_in = ST_RESULT;
               endcase
            end
         end
         ST_ZSETUP: begin
            rem_in       = {8'd0, scale_ff[26:11]};
            quo_in       = div_big ? '1 : {scale_ff[10:0], 16'd0};
            div_count_in = '0;
            state_in     = div_big ? ST_CLAMP : ST_DIV;
         end
         ST_DIV: begin
            rem_in       = div_ge ? div_sub[23:0] : div_trial[23:0];
            quo_in       = {quo_ff[25:0], div_ge};
            div_count_in = div_count_ff + DIV_COUNT_W'(1);
            if (div_count_ff == DIV_COUNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            ns_in    = ns_clamped;
            diff_in  = $signed({1'b0, scale_ff}) - $signed({1'b0, ns_clamped});
            state_in = ST_MUL_X;
         end
         ST_MUL_X: begin
            prod_in  = mul_p;
            state_in = ST_ACC_X;
         end
         ST_ACC_X: begin
            center_x_in = acc_sat;
            prod_in     = mul_p;
            state_in    = ST_ACC_Y;
         end
         ST_ACC_Y: begin
            center_y_in = acc_sat;
            if (!pan_sel) begin
               scale_in = ns_ff;
            end
            state_in = ST_RESULT;
         end
         ST_ZOP: begin
            depth_in = (op_ff == OP_SET_Z) ? zv_ff : sat32(z_sum);
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_cx_in    = center_x_ff;
               rsp_cy_in    = center_y_ff;
               rsp_scale_in = scale_ff;
               rsp_depth_in = depth_ff;
               rsp_count_in = count_ff;
               rsp_mip_in   = mip_of(scale_ff, levels_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and view state, set to their reset values by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         levels_ff    <= LEVELS_RESET;
         center_x_ff  <= HALF_Q24;
         center_y_ff  <= HALF_Q24;
         scale_ff     <= ONE_Q24;
         depth_ff     <= 32'sd0;
         count_ff     <= 32'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         levels_ff    <= levels_in;
         center_x_ff  <= center_x_in;
         center_y_ff  <= center_y_in;
         scale_ff     <= scale_in;
         depth_ff     <= depth_in;
         count_ff     <= count_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      factor_ff    <= factor_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      zv_ff        <= zv_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      div_count_ff <= div_count_in;
      ns_ff        <= ns_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      rsp_cx_ff    <= rsp_cx_in;
      rsp_cy_ff    <= rsp_cy_in;
      rsp_scale_ff <= rsp_scale_in;
      rsp_depth_ff <= rsp_depth_in;
      rsp_count_ff <= rsp_count_in;
      rsp_mip_ff   <= rsp_mip_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_view_center_x = rsp_cx_ff;
   assign rsp_view_center_y = rsp_cy_ff;
   assign rsp_view_scale    = rsp_scale_ff;
   assign rsp_view_depth    = rsp_depth_ff;
   assign rsp_change_count  = rsp_count_ff;
   assign rsp_mip_level     = rsp_mip_ff;

   // The clamp keeps the scale inside its range at all times.
   a_scale_range: assert property (@(posedge clock) disable iff (reset)
      (scale_ff >= SCALE_LO) && (scale_ff <= SCALE_HI))
      else $error("view scale left its clamped range");

   // A command transfer makes the block busy in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after a command transfer");

   // The divider never runs past its last quotient bit.
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_count_ff <= DIV_COUNT_W'(DIV_STEPS - 1)))
      else $error("divider step count overran");

   // A result only appears from the result state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("result raised outside the result state");

endmodule
